### hw/rtl/fbpb_pkg.sv
// ----------------------------------------------------------------------------
// fbpb_pkg
// Shared types, codes and helpers of the frame store fill and palette blit.
// ----------------------------------------------------------------------------
package fbpb_pkg;

  // payload widths of the command and result channels
  localparam int CMD_W   = 3;
  localparam int X_W     = 3;
  localparam int Y_W     = 4;
  localparam int COLOR_W = 16;
  localparam int BPP_W   = 2;
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 4;
  localparam int BYTE_W  = 8;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL  = 3'd0,
    CMD_HLINE  = 3'd1,
    CMD_VLINE  = 3'd2,
    CMD_RECT   = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_PAL_WR = 3'd5,
    CMD_PACKED = 3'd6,
    CMD_READ   = 3'd7
  } cmd_t;

  // packed depth codes
  localparam logic [BPP_W-1:0] BPP_1 = 2'd0;
  localparam logic [BPP_W-1:0] BPP_2 = 2'd1;
  localparam logic [BPP_W-1:0] BPP_4 = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DRAW,
    ST_CLEAR,
    ST_PAL,
    ST_PK_RD,
    ST_PK_WR,
    ST_RD,
    ST_RD_CAP,
    ST_RESP
  } state_t;

  // walk pattern of the draw state
  typedef enum logic [1:0] {
    MODE_ROW,
    MODE_COL,
    MODE_RECT
  } mode_t;

  // one result item
  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic               clipped;
  } resp_t;

  // palette index held in the top bits of a left-aligned packed byte
  function automatic logic [BYTE_W-1:0] pk_index(input logic [BYTE_W-1:0] d,
                                                 input logic [BPP_W-1:0]  bpp);
    logic [BYTE_W-1:0] idx;
    case (bpp)
      BPP_1:   idx = {7'd0, d[7]};
      BPP_2:   idx = {6'd0, d[7:6]};
      BPP_4:   idx = {4'd0, d[7:4]};
      default: idx = d;
    endcase
    return idx;
  endfunction

endpackage

### hw/rtl/fbpb_in_if.sv
// ----------------------------------------------------------------------------
// fbpb_in_if
// Command channel: valid/ready handshake with the command fields.
// ----------------------------------------------------------------------------
interface fbpb_in_if import fbpb_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [X_W-1:0]     x_start;
  logic [Y_W-1:0]     y_start;
  logic [X_W-1:0]     x_end;
  logic [Y_W-1:0]     y_end;
  logic [COLOR_W-1:0] color;
  logic [BPP_W-1:0]   bpp_code;
  logic [SLOT_W-1:0]  first_slot;
  logic [COUNT_W-1:0] pixel_count;
  logic [BYTE_W-1:0]  data_byte;
  logic [BYTE_W-1:0]  palette_index;

  modport source (
    output valid, command, x_start, y_start, x_end, y_end, color,
           bpp_code, first_slot, pixel_count, data_byte, palette_index,
    input  ready
  );

  modport sink (
    input  valid, command, x_start, y_start, x_end, y_end, color,
           bpp_code, first_slot, pixel_count, data_byte, palette_index,
    output ready
  );

endinterface

### hw/rtl/fbpb_out_if.sv
// ----------------------------------------------------------------------------
// fbpb_out_if
// Result channel: valid/ready handshake with the read colour and clip flag.
// ----------------------------------------------------------------------------
interface fbpb_out_if import fbpb_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] read_color;
  logic               clipped;

  modport source (
    output valid, read_color, clipped,
    input  ready
  );

  modport sink (
    input  valid, read_color, clipped,
    output ready
  );

endinterface

### hw/rtl/fbpb_ram.sv
// ----------------------------------------------------------------------------
// fbpb_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fbpb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/fbpb_seq.sv
// ----------------------------------------------------------------------------
// fbpb_seq
// Command sequencer: walks pixels of each command over the frame and
// palette memories and hands one result per command to the output stage.
// ----------------------------------------------------------------------------
module fbpb_seq import fbpb_pkg::*; #(
  parameter int FRAME_WIDTH   = 8,
  parameter int FRAME_HEIGHT  = 11,
  parameter int PALETTE_DEPTH = 256,
  parameter int CELL_AW       = 7,
  parameter int PAL_AW        = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  fbpb_in_if.sink            in_if,
  // frame memory
  output logic               fr_we,
  output logic [CELL_AW-1:0] fr_waddr,
  output logic [COLOR_W-1:0] fr_wdata,
  output logic               fr_re,
  output logic [CELL_AW-1:0] fr_raddr,
  input  logic [COLOR_W-1:0] fr_rdata,
  // palette memory
  output logic               pal_we,
  output logic [PAL_AW-1:0]  pal_waddr,
  output logic [COLOR_W-1:0] pal_wdata,
  output logic               pal_re,
  output logic [PAL_AW-1:0]  pal_raddr,
  input  logic [COLOR_W-1:0] pal_rdata,
  // result
  output logic               resp_valid,
  input  logic               resp_ready,
  output resp_t              resp
);

  localparam int FRAME_CELLS = FRAME_WIDTH * FRAME_HEIGHT;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  mode_t              mode_r, mode_nxt;
  logic [Y_W-1:0]     x_r, x_nxt;
  logic [Y_W-1:0]     y_r, y_nxt;
  logic [X_W-1:0]     xs_r, xs_nxt;
  logic [X_W-1:0]     xe_r, xe_nxt;
  logic [Y_W-1:0]     ye_r, ye_nxt;
  logic [COLOR_W-1:0] col_r, col_nxt;
  logic [BPP_W-1:0]   bpp_r, bpp_nxt;
  logic [BYTE_W-1:0]  data_r, data_nxt;
  logic [BYTE_W-1:0]  pidx_r, pidx_nxt;
  logic [COUNT_W-1:0] slot_r, slot_nxt;
  logic [COUNT_W-1:0] left_r, left_nxt;
  logic               clip_r, clip_nxt;
  logic               oob_r, oob_nxt;
  logic [COLOR_W-1:0] rd_r, rd_nxt;
  logic [CELL_AW-1:0] cnt_r, cnt_nxt;

  cmd_t               in_cmd;
  logic               in_acc;
  logic [COUNT_W-1:0] in_slots;
  logic [COUNT_W-1:0] in_slot;
  logic [COUNT_W-1:0] in_shift;
  logic [COUNT_W-1:0] pk_slots;
  logic [BYTE_W-1:0]  pk_idx;
  logic               pk_more;
  logic               in_frame;
  logic               row_end;
  logic               col_end;
  logic               draw_done;
  logic               cnt_end;
  logic [CELL_AW-1:0] cur_addr;

  // entry of pixel (x,y): y + x*height
  function automatic logic [CELL_AW-1:0] cell_addr(input logic [Y_W-1:0] x,
                                                   input logic [Y_W-1:0] y);
    logic [12:0] sum;
    sum = 13'(y) + 13'(x) * 13'(FRAME_HEIGHT);
    return CELL_AW'(sum);
  endfunction

  // decode of the offered command
  assign in_cmd   = cmd_t'(in_if.command);
  assign in_acc   = in_if.valid && in_if.ready;
  assign in_slots = 4'd8 >> in_if.bpp_code;
  assign in_slot  = {1'b0, in_if.first_slot} & (in_slots - 4'd1);
  assign in_shift = in_slot << in_if.bpp_code;

  // walk status
  assign in_frame  = (int'(x_r) < FRAME_WIDTH) && (int'(y_r) < FRAME_HEIGHT);
  assign row_end   = x_r >= {1'b0, xe_r};
  assign col_end   = y_r >= ye_r;
  assign cnt_end   = cnt_r == CELL_AW'(FRAME_CELLS - 1);
  assign pk_slots  = 4'd8 >> bpp_r;
  assign pk_more   = ((slot_r + 4'd1) < pk_slots) && (left_r > 4'd1);
  assign pk_idx    = pk_index(data_r, bpp_r);
  assign cur_addr  = cell_addr(x_r, y_r);

  always_comb begin
    case (mode_r)
      MODE_ROW:  draw_done = row_end;
      MODE_COL:  draw_done = col_end;
      MODE_RECT: draw_done = row_end && col_end;
      default:   draw_done = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (cnt_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_PIXEL, CMD_HLINE, CMD_VLINE: state_nxt = ST_DRAW;
            CMD_RECT: begin
              state_nxt = (in_if.y_start > in_if.y_end) ? ST_RESP : ST_DRAW;
            end
            CMD_CLEAR:  state_nxt = ST_CLEAR;
            CMD_PAL_WR: state_nxt = ST_PAL;
            CMD_PACKED: begin
              state_nxt = (in_if.pixel_count == '0) ? ST_RESP : ST_PK_RD;
            end
            default:    state_nxt = ST_RD;
          endcase
        end
      end
      ST_DRAW: begin
        if (draw_done) state_nxt = ST_RESP;
      end
      ST_CLEAR: begin
        if (cnt_end) state_nxt = ST_RESP;
      end
      ST_PAL:    state_nxt = ST_RESP;
      ST_PK_RD:  state_nxt = ST_PK_WR;
      ST_PK_WR:  state_nxt = pk_more ? ST_PK_RD : ST_RESP;
      ST_RD:     state_nxt = ST_RD_CAP;
      ST_RD_CAP: state_nxt = ST_RESP;
      ST_RESP: begin
        if (resp_ready) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_INIT;
    endcase
  end

  // memory ports and handshake outputs
  always_comb begin
    in_if.ready = 1'b0;
    fr_we       = 1'b0;
    fr_waddr    = cur_addr;
    fr_wdata    = col_r;
    fr_re       = 1'b0;
    pal_we      = 1'b0;
    pal_re      = 1'b0;
    resp_valid  = 1'b0;
    case (state_r)
      ST_INIT: begin
        fr_we    = 1'b1;
        fr_waddr = cnt_r;
        fr_wdata = '0;
      end
      ST_IDLE:  in_if.ready = 1'b1;
      ST_DRAW:  fr_we = in_frame;
      ST_CLEAR: begin
        fr_we    = 1'b1;
        fr_waddr = cnt_r;
      end
      ST_PAL:   pal_we = int'(pidx_r) < PALETTE_DEPTH;
      ST_PK_RD: pal_re = 1'b1;
      ST_PK_WR: begin
        fr_we    = in_frame;
        fr_wdata = oob_r ? '0 : pal_rdata;
      end
      ST_RD:    fr_re = 1'b1;
      ST_RESP:  resp_valid = 1'b1;
      default:  in_if.ready = 1'b0;
    endcase
  end

  assign fr_raddr  = cur_addr;
  assign pal_waddr = PAL_AW'(pidx_r);
  assign pal_wdata = col_r;
  assign pal_raddr = PAL_AW'(pk_idx);
  assign resp      = '{read_color: rd_r, clipped: clip_r};

  // walk registers
  always_comb begin
    cmd_nxt  = cmd_r;
    mode_nxt = mode_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    xs_nxt   = xs_r;
    xe_nxt   = xe_r;
    ye_nxt   = ye_r;
    col_nxt  = col_r;
    bpp_nxt  = bpp_r;
    data_nxt = data_r;
    pidx_nxt = pidx_r;
    slot_nxt = slot_r;
    left_nxt = left_r;
    clip_nxt = clip_r;
    oob_nxt  = oob_r;
    rd_nxt   = rd_r;
    cnt_nxt  = cnt_r;
    case (state_r)
      ST_INIT: cnt_nxt = cnt_r + CELL_AW'(1);
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_cmd;
          x_nxt    = {1'b0, in_if.x_start};
          y_nxt    = in_if.y_start;
          xs_nxt   = in_if.x_start;
          xe_nxt   = (in_cmd == CMD_PIXEL) ? in_if.x_start : in_if.x_end;
          ye_nxt   = in_if.y_end;
          col_nxt  = in_if.color;
          bpp_nxt  = in_if.bpp_code;
          data_nxt = in_if.data_byte << in_shift;
          pidx_nxt = in_if.palette_index;
          slot_nxt = in_slot;
          left_nxt = in_if.pixel_count;
          clip_nxt = 1'b0;
          rd_nxt   = '0;
          cnt_nxt  = '0;
          case (in_cmd)
            CMD_VLINE: mode_nxt = MODE_COL;
            CMD_RECT:  mode_nxt = MODE_RECT;
            default:   mode_nxt = MODE_ROW;
          endcase
        end
      end
      ST_DRAW: begin
        if (!in_frame) clip_nxt = 1'b1;
        case (mode_r)
          MODE_ROW: begin
            if (!row_end) x_nxt = x_r + 4'd1;
          end
          MODE_COL: begin
            if (!col_end) y_nxt = y_r + 4'd1;
          end
          MODE_RECT: begin
            // row done: back to the left edge of the next row
            if (row_end) begin
              if (!col_end) begin
                y_nxt = y_r + 4'd1;
                x_nxt = {1'b0, xs_r};
              end
            end else begin
              x_nxt = x_r + 4'd1;
            end
          end
          default: x_nxt = x_r;
        endcase
      end
      ST_CLEAR: cnt_nxt = cnt_r + CELL_AW'(1);
      ST_PK_RD: oob_nxt = int'(pk_idx) >= PALETTE_DEPTH;
      ST_PK_WR: begin
        if (!in_frame) clip_nxt = 1'b1;
        x_nxt    = x_r + 4'd1;
        slot_nxt = slot_r + 4'd1;
        left_nxt = left_r - 4'd1;
        data_nxt = data_r << (4'd1 << bpp_r);
      end
      ST_RD_CAP: rd_nxt = in_frame ? fr_rdata : '0;
      default:   rd_nxt = rd_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    mode_r <= mode_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    xs_r   <= xs_nxt;
    xe_r   <= xe_nxt;
    ye_r   <= ye_nxt;
    col_r  <= col_nxt;
    bpp_r  <= bpp_nxt;
    data_r <= data_nxt;
    pidx_r <= pidx_nxt;
    slot_r <= slot_nxt;
    left_r <= left_nxt;
    clip_r <= clip_nxt;
    oob_r  <= oob_nxt;
    rd_r   <= rd_nxt;
  end

`ifndef SYNTH
  // frame writes stay inside the store
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fr_we |-> (int'(fr_waddr) < FRAME_CELLS))
    else $error("frame write beyond the store");

  // a palette lookup is always consumed by a pixel write the next cycle
  a_pk_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PK_RD) |=> (state_r == ST_PK_WR))
    else $error("palette lookup not followed by its pixel write");

  // non-drawing commands never report clipping
  a_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    resp_valid && (cmd_r == CMD_CLEAR || cmd_r == CMD_PAL_WR || cmd_r == CMD_READ)
    |-> !resp.clipped)
    else $error("clip flagged on a non-drawing command");

  // only a read returns a colour
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    resp_valid && (cmd_r != CMD_READ) |-> (resp.read_color == '0))
    else $error("colour returned for a non-read command");

  // a result transfer returns the sequencer to idle
  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    resp_valid && resp_ready |=> (state_r == ST_IDLE))
    else $error("sequencer not idle after result transfer");
`endif

endmodule

### hw/rtl/fbpb_out_stage.sv
// ----------------------------------------------------------------------------
// fbpb_out_stage
// One-entry output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module fbpb_out_stage import fbpb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       resp_valid,
  output logic       resp_ready,
  input  resp_t      resp,
  fbpb_out_if.source out_if
);

  logic  valid_r, valid_nxt;
  resp_t data_r, data_nxt;
  logic  load;

  // slot is free when empty or draining this cycle
  assign resp_ready = !valid_r || out_if.ready;
  assign load       = resp_valid && resp_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = resp;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_if.valid      = valid_r;
  assign out_if.read_color = data_r.read_color;
  assign out_if.clipped    = data_r.clipped;

endmodule

### hw/rtl/framebuffer_fill_and_palette_blit_top.sv
// ----------------------------------------------------------------------------
// framebuffer_fill_and_palette_blit_top
// Command-driven 16-bit frame store with line, rectangle and clear fills and
// packed-byte expansion through a palette.
// ----------------------------------------------------------------------------
// Each command gives exactly one result. Pixel (x,y) sits at entry
// y + x*FRAME_HEIGHT of a single-port-write frame RAM. A command passes
// through the command transfer, its memory accesses and the hand-over
// of the result; a rectangle whose top is below its bottom makes no access,
// and each pixel of a packed byte first waits on a palette RAM read. After
// reset the block sweeps the frame to zero, one entry a cycle, before it
// takes the first command. The output register lets the next command be
// taken while a result waits.
// Palette entries must be written before a packed byte uses them.
// ----------------------------------------------------------------------------
module framebuffer_fill_and_palette_blit_top import fbpb_pkg::*; #(
  parameter int FRAME_WIDTH   = 8,
  parameter int FRAME_HEIGHT  = 11,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  fbpb_in_if.sink    in_if,
  fbpb_out_if.source out_if
);

  localparam int FRAME_CELLS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int CELL_AW     = (FRAME_CELLS > 1) ? $clog2(FRAME_CELLS) : 1;
  localparam int PAL_AW      = $clog2(PALETTE_DEPTH);

  logic               fr_we;
  logic [CELL_AW-1:0] fr_waddr;
  logic [COLOR_W-1:0] fr_wdata;
  logic               fr_re;
  logic [CELL_AW-1:0] fr_raddr;
  logic [COLOR_W-1:0] fr_rdata;
  logic               pal_we;
  logic [PAL_AW-1:0]  pal_waddr;
  logic [COLOR_W-1:0] pal_wdata;
  logic               pal_re;
  logic [PAL_AW-1:0]  pal_raddr;
  logic [COLOR_W-1:0] pal_rdata;
  logic               resp_valid;
  logic               resp_ready;
  resp_t              resp;

  // command sequencer
  fbpb_seq #(
    .FRAME_WIDTH   (FRAME_WIDTH),
    .FRAME_HEIGHT  (FRAME_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .CELL_AW       (CELL_AW),
    .PAL_AW        (PAL_AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .fr_we      (fr_we),
    .fr_waddr   (fr_waddr),
    .fr_wdata   (fr_wdata),
    .fr_re      (fr_re),
    .fr_raddr   (fr_raddr),
    .fr_rdata   (fr_rdata),
    .pal_we     (pal_we),
    .pal_waddr  (pal_waddr),
    .pal_wdata  (pal_wdata),
    .pal_re     (pal_re),
    .pal_raddr  (pal_raddr),
    .pal_rdata  (pal_rdata),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp)
  );

  // frame store
  fbpb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (FRAME_CELLS),
    .AW    (CELL_AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .re    (fr_re),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  // palette store
  fbpb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH),
    .AW    (PAL_AW)
  ) u_palette_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  // result register
  fbpb_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp),
    .out_if     (out_if)
  );

endmodule
